### design/gelu_pkg.sv
package gelu_pkg;

  // One input beat: a signed sample and the end-of-vector flag.
  typedef struct packed {
    logic signed [15:0] x_in;
    logic               in_last;
  } gelu_in_t;

  // One output beat.
  typedef struct packed {
    logic signed [15:0] y_out;
    logic               out_last;
  } gelu_out_t;

  // 0.797884560802 and 0.044715 in Q30.
  localparam logic [29:0] COEF_C1  = 30'd856722024;
  localparam logic [25:0] COEF_C3  = 26'd48012366;
  // 1.0 in Q16, the scale of the tanh table.
  localparam logic [16:0] TANH_ONE = 17'h10000;
  localparam logic [63:0] Q30_ONE  = 64'h4000_0000;

  // Unsigned quotient by long division. Only evaluated at elaboration.
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], n[i]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // tanh(v/2) in Q16 for v in Q30, built as (1-e)/(1+e) with e = exp(-v).
  // exp(-v) comes from a Taylor sum of exp(-v/16) to the 20th power that is squared
  // four times. Only used to fill constant tables at elaboration.
  function automatic logic [16:0] tanh_q16(input logic [63:0] v);
    logic [63:0] w;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] q;
    w    = v >> 4;
    sum  = Q30_ONE;
    term = Q30_ONE;
    for (int k = 1; k <= 20; k++) begin
      term = udiv64((term * w) >> 30, 64'(k));
      if ((k & 1) == 1) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    for (int k = 0; k < 4; k++) begin
      sum = (sum * sum + (64'd1 << 29)) >> 30;
    end
    if (sum > Q30_ONE) begin
      sum = Q30_ONE;
    end
    num = (Q30_ONE - sum) << 16;
    den = Q30_ONE + sum;
    q   = udiv64(num + (den >> 1), den);
    return q[16:0];
  endfunction

endpackage

### design/gelu_tanh_rom.sv
module gelu_tanh_rom #(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic [$clog2(TABLE_ENTRIES)-1:0] idx_i,
  output logic [16:0]                      lo_o,
  output logic [16:0]                      hi_o
);
  import gelu_pkg::*;

  // Two views of the same tanh table over [0,4): entry i and entry i+1,
  // so one index reads both ends of an interpolation segment.
  logic [16:0] lo_rom [TABLE_ENTRIES];
  logic [16:0] hi_rom [TABLE_ENTRIES];
  logic [16:0] lo_q;
  logic [16:0] hi_q;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_rom
    localparam logic [63:0] V_LO = (64'(g) << 33) / TABLE_ENTRIES;
    localparam logic [63:0] V_HI = (64'(g + 1) << 33) / TABLE_ENTRIES;
    localparam logic [16:0] T_LO = tanh_q16(V_LO);
    localparam logic [16:0] T_HI = tanh_q16(V_HI);
    assign lo_rom[g] = T_LO;
    assign hi_rom[g] = T_HI;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_q <= lo_rom[idx_i];
      hi_q <= hi_rom[idx_i];
    end
  end

  assign lo_o = lo_q;
  assign hi_o = hi_q;

endmodule

### design/gelu_tanh_activation.sv
// GELU activation, tanh form, on a stream of signed fixed-point samples.
//
// Input channel in_*: one sample and its end-of-vector flag per beat. Output
// channel out_*: one result beat for every input beat, in order, with the
// flag copied through. A beat moves on an edge where valid is high and stall
// is low on that channel.
//
// The datapath is a ten-stage pipeline: absolute value, square, cube, cubic
// coefficient, inner sum, tanh argument, table index, table read, tanh
// interpolation, final product with rounding. Every multiplier sits in a
// stage of its own. Throughput is one sample per cycle while the output is
// not stalled.
//
// Each stage holds a valid bit and advances whenever it is empty or the stage
// after it advances, so a stall on the output only backs up into the input
// once every stage holds a sample; empty stages still fill meanwhile.
// Reset clears all valid bits; the tanh table is constant and needs no load.
module gelu_tanh_activation #(
  parameter int TABLE_ENTRIES = 256,
  parameter int FRAC_BITS     = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  gelu_pkg::gelu_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output gelu_pkg::gelu_out_t out_data_o
);
  import gelu_pkg::*;

  localparam int NS   = 10;
  // Magnitudes below 4.0 need at most AW bits.
  localparam int AW   = (FRAC_BITS + 2 < 16) ? FRAC_BITS + 2 : 16;
  localparam int CUW  = 3 * AW;
  localparam int CSW  = CUW - FRAC_BITS;
  localparam int DPW  = (CSW + 26 > 2 * FRAC_BITS + 32) ? CSW + 26 : 2 * FRAC_BITS + 32;
  localparam int SH   = 30 - FRAC_BITS;
  localparam int IDXW = $clog2(TABLE_ENTRIES);
  localparam int NW   = $clog2(TABLE_ENTRIES + 1);
  localparam int PW   = 33 + NW;
  localparam logic [31:0] BIG_LIM = 32'd1 << (FRAC_BITS + 2);
  localparam logic [32:0] U_LIM   = 33'h1_0000_0000;

  typedef struct packed {
    logic [15:0] a;
    logic        neg;
    logic        big;
    logic        last;
  } side_t;

  function automatic logic [AW-1:0] small_mag(input side_t s);
    return s.big ? '0 : s.a[AW-1:0];
  endfunction

  logic [NS:1]       vld_q;
  logic [NS:1]       rdy;
  side_t             side_q [1:NS];
  side_t             side_d;

  logic [2*AW-1:0]   sq_q;
  logic [CSW-1:0]    cs_q;
  logic [31:0]       cq_q;
  logic [32:0]       inner_q;
  logic [32:0]       u_q;
  logic [IDXW-1:0]   idx_q;
  logic [15:0]       f7_q;
  logic [15:0]       f8_q;
  logic              sat7_q;
  logic              sat8_q;
  logic [17:0]       g_q;
  gelu_out_t         out_q;

  logic [CUW-1:0]    cube;
  logic [DPW-1:0]    cprod;
  logic [62:0]       uprod;
  logic [PW-1:0]     p;
  logic              sat_d;
  logic [16:0]       lo;
  logic [16:0]       hi;
  logic [16:0]       dlt;
  logic [32:0]       dprod;
  logic [16:0]       t;
  logic [17:0]       g_d;
  logic [34:0]       yprod;
  logic [17:0]       mag;
  logic [16:0]       mag_sat;
  logic [15:0]       y_d;

  // Handshake: a stage loads when it is empty or its successor loads.
  always_comb begin
    rdy[NS] = !vld_q[NS] || !out_stall_i;
    for (int k = NS - 1; k >= 1; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign in_stall_o = !rdy[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[1]) begin
        vld_q[1] <= in_valid_i;
      end
      for (int k = 2; k <= NS; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Stage 1: sign and magnitude. The most negative sample becomes 32768.
  always_comb begin
    side_d.neg  = in_data_i.x_in[15];
    side_d.a    = side_d.neg ? 16'(17'h10000 - {1'b0, in_data_i.x_in})
                             : in_data_i.x_in;
    side_d.big  = {16'd0, side_d.a} >= BIG_LIM;
    side_d.last = in_data_i.in_last;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      side_q[1] <= side_d;
    end
    for (int k = 2; k <= NS; k++) begin
      if (rdy[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // Stages 2 to 6: u = C1 * (a + C3 * a^3), all in Q30.
  assign cube  = CUW'(sq_q) * CUW'(small_mag(side_q[2]));
  assign cprod = DPW'(cs_q) * DPW'(COEF_C3);
  assign uprod = 63'(inner_q) * 63'(COEF_C1);

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      sq_q <= (2*AW)'(small_mag(side_q[1])) * (2*AW)'(small_mag(side_q[1]));
    end
    if (rdy[3]) begin
      cs_q <= cube[CUW-1:FRAC_BITS];
    end
    if (rdy[4]) begin
      cq_q <= cprod[2*FRAC_BITS +: 32];
    end
    if (rdy[5]) begin
      inner_q <= (33'(small_mag(side_q[4])) << SH) + 33'(cq_q);
    end
    if (rdy[6]) begin
      u_q <= uprod[62:30];
    end
  end

  // Stage 7: table segment and fraction. Saturated samples read entry zero.
  assign p     = PW'(u_q) * PW'(TABLE_ENTRIES);
  assign sat_d = side_q[6].big || (u_q >= U_LIM);

  always_ff @(posedge clk_i) begin
    if (rdy[7]) begin
      idx_q  <= sat_d ? '0 : p[32 +: IDXW];
      f7_q   <= p[31:16];
      sat7_q <= sat_d;
    end
    if (rdy[8]) begin
      f8_q   <= f7_q;
      sat8_q <= sat7_q;
    end
  end

  // Stage 8: table read.
  gelu_tanh_rom #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_rom (
    .clk_i (clk_i),
    .en_i  (rdy[8]),
    .idx_i (idx_q),
    .lo_o  (lo),
    .hi_o  (hi)
  );

  // Stage 9: interpolated tanh, then 1 + tanh(u) with the sign of x.
  always_comb begin
    dlt   = (hi >= lo) ? hi - lo : 17'd0;
    dprod = 33'(dlt) * 33'(f8_q);
    t     = sat8_q ? TANH_ONE : lo + dprod[32:16];
    g_d   = side_q[8].neg ? 18'(TANH_ONE) - 18'(t) : 18'(TANH_ONE) + 18'(t);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[9]) begin
      g_q <= g_d;
    end
  end

  // Stage 10: |y| = (a * g + 2^16) >> 17 rounds half away from zero.
  always_comb begin
    yprod = 35'(side_q[9].a) * 35'(g_q) + (35'd1 << 16);
    mag   = yprod[34:17];
    if (side_q[9].neg) begin
      mag_sat = (mag > 18'd32768) ? 17'd32768 : mag[16:0];
      y_d     = 16'(17'h10000 - mag_sat);
    end else begin
      mag_sat = (mag > 18'd32767) ? 17'd32767 : mag[16:0];
      y_d     = mag_sat[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[10]) begin
      out_q.y_out    <= y_d;
      out_q.out_last <= side_q[9].last;
    end
  end

  assign out_valid_o = vld_q[NS];
  assign out_data_o  = out_q;

  // The input only backs up when every stage is occupied.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&vld_q))
    else $error("input stalled while the pipeline has an empty stage");

  // A non-negative sample never yields a negative result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !side_q[NS].neg) |-> !out_data_o.y_out[15])
    else $error("negative result for a non-negative sample");

  // At or above the cutoff, positive samples pass through unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && side_q[NS].big && !side_q[NS].neg)
      |-> (out_data_o.y_out == side_q[NS].a))
    else $error("large positive sample not passed through");

  // At or below minus the cutoff, the result is zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && side_q[NS].big && side_q[NS].neg) |-> (out_data_o.y_out == '0))
    else $error("large negative sample did not give zero");

endmodule
